@@ rtl/ohat_pkg.sv @@
// ohat_pkg: shared types, codes and constants of the open addressing hash table
// used by every module of the block, no dependencies

package ohat_pkg;

    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int VAL_W         = 31;
    localparam int CNT_W         = 11;
    localparam int STAT_W        = 2;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int REM_W         = CNT_W + 1;
    localparam int MAX_KEY_CHARS = 8;
    localparam int DEF_SLOTS     = 1024;
    localparam int DIV_STEPS     = KEY_W / 2;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] SIZE_RESET  = CNT_W'(13);
    localparam logic [KEY_W-1:0] DJB_SEED    = KEY_W'(5381);
    localparam logic [KEY_W-1:0] POLY_OFFSET = KEY_W'(96);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_GONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd2;

    typedef struct packed {
        logic             probe_mode;
        logic             hash_select;
        logic [CNT_W-1:0] size;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  base;
        logic [CNT_W-1:0]  step;
    } t_job;

endpackage

@@ rtl/open_addressing_hash_table_unit.sv @@
// open_addressing_hash_table_unit: top level of the string-keyed hash table
// flow: the front hashes and reduces the key, the queue holds it, the back probes slots
// throughput: one request at a time in the back; the front hashes the next meanwhile
// the probe walk is set by the single-port slot memories, one read per probe
// reset: synchronous, active low; a clearing pass after reset empties every slot
// depends on ohat_pkg, ohat_front, ohat_queue, ohat_back

module open_addressing_hash_table_unit import ohat_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [KEY_W-1:0]     i_key_chars,
    input  logic [LEN_W-1:0]     i_key_len,
    input  logic [VAL_W-1:0]     i_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [VAL_W-1:0]     o_found_value,
    output logic [CNT_W-1:0]     o_probe_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    logic             r_probe_mode;
    logic             r_hash_select;
    logic [CNT_W-1:0] r_table_size;
    logic [CNT_W-1:0] w_n;
    t_cfg             w_cfg;
    logic             w_front_ready;
    logic             w_clearing;
    logic             w_fv, w_fr, w_qv, w_qr;
    t_job             w_fjob, w_qjob;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode  <= 1'b0;
            r_hash_select <= 1'b0;
            r_table_size  <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROBE_MODE: r_probe_mode  <= i_cfg_data[0];
                CFG_HASH_SEL:   r_hash_select <= i_cfg_data[0];
                CFG_TABLE_SIZE: r_table_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_table_size < CNT_W'(2)) begin
            w_n = CNT_W'(2);
        end else if (32'(r_table_size) > SLOTS) begin
            w_n = CNT_W'(SLOTS);
        end else begin
            w_n = r_table_size;
        end
    end

    assign w_cfg.probe_mode  = r_probe_mode;
    assign w_cfg.hash_select = r_hash_select;
    assign w_cfg.size        = w_n;

    assign o_ready = w_front_ready && !w_clearing;

    ohat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid && !w_clearing),
        .o_ready     (w_front_ready),
        .i_func      (i_func),
        .i_key_chars (i_key_chars),
        .i_key_len   (i_key_len),
        .i_value     (i_value),
        .i_cfg       (w_cfg),
        .o_job_valid (w_fv),
        .i_job_ready (w_fr),
        .o_job       (w_fjob)
    );

    ohat_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fv),
        .o_push_ready (w_fr),
        .i_push_data  (w_fjob),
        .o_pop_valid  (w_qv),
        .i_pop_ready  (w_qr),
        .o_pop_data   (w_qjob)
    );

    ohat_back #(.SLOTS(SLOTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_qv),
        .o_job_ready   (w_qr),
        .i_job         (w_qjob),
        .i_cfg         (w_cfg),
        .o_clearing    (w_clearing),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_probe_count (o_probe_count)
    );

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_ready)
        else $error("transaction accepted during clearing pass");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_MISS || o_status == STAT_FULL))
        else $error("bad status code");

    a_value_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_found_value == '0))
        else $error("value reported without a hit");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_probe_count <= w_n))
        else $error("probe count beyond table size");

endmodule

@@ rtl/ohat_front.sv @@
// ohat_front: accepts requests, hashes the key one character a cycle and reduces the
// base hash modulo the table size and the step hash modulo size minus one, two bits a cycle; uses ohat_pkg

module ohat_front import ohat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [KEY_W-1:0]  i_key_chars,
    input  logic [LEN_W-1:0]  i_key_len,
    input  logic [VAL_W-1:0]  i_value,
    input  t_cfg              i_cfg,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output t_job              o_job
);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_DIV, F_PUSH} t_fstate;

    t_fstate               r_state, n_state;
    logic [FUNC_W-1:0]     r_func, n_func;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [VAL_W-1:0]      r_value, n_value;
    logic [KEY_W-1:0]      r_poly, n_poly;
    logic [KEY_W-1:0]      r_djb, n_djb;
    logic [LEN_W-1:0]      r_k, n_k;
    logic [DIV_CNT_W-1:0]  r_div, n_div;
    logic [KEY_W-1:0]      r_num_b, n_num_b;
    logic [KEY_W-1:0]      r_num_s, n_num_s;
    logic [REM_W-1:0]      r_rb, n_rb;
    logic [REM_W-1:0]      r_rs, n_rs;

    logic [LEN_W-1:0]      w_len_eff;
    logic [KEY_W-1:0]      w_key_masked;
    logic [KEY_W-1:0]      w_char;
    logic [REM_W-1:0]      w_div_b;
    logic [REM_W-1:0]      w_div_s;

    function automatic logic [REM_W-1:0] rem_step(
        input logic [REM_W-1:0] rem,
        input logic             din,
        input logic [REM_W-1:0] d
    );
        logic [REM_W-1:0] t;
        t = {rem[REM_W-2:0], din};
        if (t >= d) begin
            t = t - d;
        end
        return t;
    endfunction

    always_comb begin
        if (i_key_len > LEN_W'(MAX_KEY_CHARS)) begin
            w_len_eff = LEN_W'(MAX_KEY_CHARS);
        end else begin
            w_len_eff = i_key_len;
        end
        for (int b = 0; b < KEY_W / 8; b++) begin
            w_key_masked[8*b +: 8] = (LEN_W'(b) < w_len_eff) ? i_key_chars[8*b +: 8] : 8'd0;
        end
    end

    assign w_char  = KEY_W'(r_key[{r_k[2:0], 3'b000} +: 8]);
    assign w_div_b = REM_W'(i_cfg.size);
    assign w_div_s = REM_W'(i_cfg.size) - REM_W'(1);

    assign o_ready          = (r_state == F_IDLE);
    assign o_job_valid      = (r_state == F_PUSH);
    assign o_job.func       = r_func;
    assign o_job.key        = r_key;
    assign o_job.len        = r_len;
    assign o_job.value      = r_value;
    assign o_job.base       = r_rb[CNT_W-1:0];
    assign o_job.step       = r_rs[CNT_W-1:0] + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_key   = r_key;
        n_len   = r_len;
        n_value = r_value;
        n_poly  = r_poly;
        n_djb   = r_djb;
        n_k     = r_k;
        n_div   = r_div;
        n_num_b = r_num_b;
        n_num_s = r_num_s;
        n_rb    = r_rb;
        n_rs    = r_rs;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_func  = i_func;
                    n_key   = w_key_masked;
                    n_len   = w_len_eff;
                    n_value = i_value;
                    n_poly  = '0;
                    n_djb   = DJB_SEED;
                    n_k     = '0;
                    n_state = F_HASH;
                end
            end
            F_HASH: begin
                if (r_k == r_len) begin
                    n_num_b = i_cfg.hash_select ? r_djb : r_poly;
                    n_num_s = r_poly;
                    n_rb    = '0;
                    n_rs    = '0;
                    n_div   = '0;
                    n_state = F_DIV;
                end else begin
                    n_poly = (r_poly << 5) - r_poly + w_char - POLY_OFFSET;
                    n_djb  = (r_djb << 5) + r_djb + w_char;
                    n_k    = r_k + LEN_W'(1);
                end
            end
            F_DIV: begin
                n_rb    = rem_step(rem_step(r_rb, r_num_b[KEY_W-1], w_div_b),
                                   r_num_b[KEY_W-2], w_div_b);
                n_rs    = rem_step(rem_step(r_rs, r_num_s[KEY_W-1], w_div_s),
                                   r_num_s[KEY_W-2], w_div_s);
                n_num_b = r_num_b << 2;
                n_num_s = r_num_s << 2;
                n_div   = r_div + DIV_CNT_W'(1);
                if (r_div == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_func  <= n_func;
        r_key   <= n_key;
        r_len   <= n_len;
        r_value <= n_value;
        r_poly  <= n_poly;
        r_djb   <= n_djb;
        r_k     <= n_k;
        r_div   <= n_div;
        r_num_b <= n_num_b;
        r_num_s <= n_num_s;
        r_rb    <= n_rb;
        r_rs    <= n_rs;
    end

endmodule

@@ rtl/ohat_queue.sv @@
// ohat_queue: two-entry queue of hashed requests between front and back
// uses t_job from ohat_pkg

module ohat_queue import ohat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

@@ rtl/ohat_back.sv @@
// ohat_back: slot memories and the probe walk, each probe a read state then a check
// state, with the result register; uses ohat_pkg

module ohat_back import ohat_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    input  t_cfg              i_cfg,
    output logic              o_clearing,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [VAL_W-1:0]  o_found_value,
    output logic [CNT_W-1:0]  o_probe_count
);

    localparam int AW = $clog2(SLOTS);

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK, B_DONE} t_bstate;

    logic [1:0]        r_mark [SLOTS];
    logic [KEY_W-1:0]  r_skey [SLOTS];
    logic [LEN_W-1:0]  r_slen [SLOTS];
    logic [VAL_W-1:0]  r_sval [SLOTS];
    logic [1:0]        r_mark_q;
    logic [KEY_W-1:0]  r_key_q;
    logic [LEN_W-1:0]  r_len_q;
    logic [VAL_W-1:0]  r_val_q;

    t_bstate           r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    t_job              r_job, n_job;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_d, n_d;
    logic [CNT_W-1:0]  r_hits, n_hits;
    logic [STAT_W-1:0] r_res_st, n_res_st;
    logic [VAL_W-1:0]  r_res_val, n_res_val;
    logic [CNT_W-1:0]  r_res_cnt, n_res_cnt;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_st, n_out_st;
    logic [VAL_W-1:0]  r_out_val, n_out_val;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic              w_we_mark, w_we_data;
    logic [1:0]        w_mark_wd;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic              w_match;
    logic [REM_W-1:0]  w_t1, w_t2, w_d2;
    logic [CNT_W-1:0]  w_p1, w_p2, w_dn;

    assign w_raddr  = AW'(r_pos);
    assign w_waddr  = (r_state == B_CLEAR) ? r_clr : w_raddr;
    assign w_match  = (r_mark_q == MARK_USED) && (r_len_q == r_job.len) && (r_key_q == r_job.key);

    // next probe position and square term increment
    always_comb begin
        w_t1 = REM_W'(r_pos) + REM_W'(r_job.step);
        w_p1 = (w_t1 >= REM_W'(i_cfg.size)) ? CNT_W'(w_t1 - REM_W'(i_cfg.size)) : CNT_W'(w_t1);
        w_t2 = REM_W'(w_p1) + REM_W'(r_d);
        w_p2 = (w_t2 >= REM_W'(i_cfg.size)) ? CNT_W'(w_t2 - REM_W'(i_cfg.size)) : CNT_W'(w_t2);
        w_d2 = REM_W'(r_d) + REM_W'(2);
        w_dn = (w_d2 >= REM_W'(i_cfg.size)) ? CNT_W'(w_d2 - REM_W'(i_cfg.size)) : CNT_W'(w_d2);
    end

    assign o_job_ready   = (r_state == B_IDLE);
    assign o_clearing    = (r_state == B_CLEAR);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_st;
    assign o_found_value = r_out_val;
    assign o_probe_count = r_out_cnt;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_job       = r_job;
        n_pos       = r_pos;
        n_d         = r_d;
        n_hits      = r_hits;
        n_res_st    = r_res_st;
        n_res_val   = r_res_val;
        n_res_cnt   = r_res_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_st    = r_out_st;
        n_out_val   = r_out_val;
        n_out_cnt   = r_out_cnt;
        w_we_mark   = 1'b0;
        w_we_data   = 1'b0;
        w_mark_wd   = MARK_EMPTY;
        unique case (r_state)
            B_CLEAR: begin
                w_we_mark = 1'b1;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_job_valid) begin
                    n_job     = i_job;
                    n_pos     = i_job.base;
                    n_d       = CNT_W'(1);
                    n_hits    = CNT_W'(1);
                    n_res_st  = STAT_MISS;
                    n_res_val = '0;
                    n_res_cnt = '0;
                    if (i_job.func == FUNC_INSERT || i_job.func == FUNC_REMOVE ||
                        i_job.func == FUNC_SEARCH) begin
                        n_state = B_READ;
                    end else begin
                        n_state = B_DONE;
                    end
                end
            end
            B_READ: begin
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (r_job.func == FUNC_INSERT && r_mark_q != MARK_USED) begin
                    w_we_mark = 1'b1;
                    w_we_data = 1'b1;
                    w_mark_wd = MARK_USED;
                    n_res_st  = STAT_OK;
                    n_state   = B_DONE;
                end else if (r_job.func != FUNC_INSERT && r_mark_q == MARK_EMPTY) begin
                    n_res_st  = STAT_MISS;
                    n_res_cnt = (r_job.func == FUNC_SEARCH) ? r_hits : '0;
                    n_state   = B_DONE;
                end else if (r_job.func != FUNC_INSERT && w_match) begin
                    n_res_st = STAT_OK;
                    if (r_job.func == FUNC_REMOVE) begin
                        w_we_mark = 1'b1;
                        w_mark_wd = MARK_GONE;
                    end else begin
                        n_res_val = r_val_q;
                        n_res_cnt = r_hits;
                    end
                    n_state = B_DONE;
                end else if (r_hits == i_cfg.size) begin
                    n_res_st  = (r_job.func == FUNC_INSERT) ? STAT_FULL : STAT_MISS;
                    n_res_cnt = (r_job.func == FUNC_SEARCH) ? r_hits : '0;
                    n_state   = B_DONE;
                end else begin
                    n_pos   = i_cfg.probe_mode ? w_p2 : w_p1;
                    n_d     = w_dn;
                    n_hits  = r_hits + CNT_W'(1);
                    n_state = B_READ;
                end
            end
            B_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_val   = r_res_val;
                    n_out_cnt   = r_res_cnt;
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_job     <= n_job;
        r_pos     <= n_pos;
        r_d       <= n_d;
        r_hits    <= n_hits;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
        r_res_cnt <= n_res_cnt;
        r_out_st  <= n_out_st;
        r_out_val <= n_out_val;
        r_out_cnt <= n_out_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (w_we_mark) begin
            r_mark[w_waddr] <= w_mark_wd;
        end
        r_mark_q <= r_mark[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_data) begin
            r_skey[w_waddr] <= r_job.key;
            r_slen[w_waddr] <= r_job.len;
            r_sval[w_waddr] <= r_job.value;
        end
        r_key_q <= r_skey[w_raddr];
        r_len_q <= r_slen[w_raddr];
        r_val_q <= r_sval[w_raddr];
    end

endmodule
